// ===== sv/qsqrt_pkg.sv =====
// Package: widths, constants, sequencer states and result type of the Q16.16 square root core.
package qsqrt_pkg;

   localparam int VALUE_W = 32;
   localparam int FRAC_W  = 16;
   localparam int INT_W   = VALUE_W - FRAC_W - 1;
   localparam int ROOT_W  = 24;
   localparam int OPER_W  = 32;
   localparam int CNT_W   = 4;
   localparam int C_W     = 16;
   localparam int D_W     = 9;

   localparam logic [OPER_W-1:0] ONE_Q       = OPER_W'(32'h10000);
   localparam logic [CNT_W-1:0]  C_START_CNT = CNT_W'(15);
   localparam logic [CNT_W-1:0]  F_START_CNT = CNT_W'(15);
   localparam logic [CNT_W-1:0]  DIV_START_CNT = CNT_W'(15);
   localparam logic [CNT_W-1:0]  D_START_CNT = CNT_W'(8);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT_C,
      ST_DIV,
      ST_ROOT_D,
      ST_ROOT_F,
      ST_MUL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [ROOT_W-1:0] root;
      logic              is_nan;
   } result_type;

endpackage

// ===== sv/qsqrt_csub.sv =====
// Shared compare-and-subtract unit used by the root and divide steps.
module qsqrt_csub (
   input  logic [qsqrt_pkg::OPER_W-1:0] oper_a,
   input  logic [qsqrt_pkg::OPER_W-1:0] oper_b,
   output logic                         a_ge_b,
   output logic [qsqrt_pkg::OPER_W-1:0] a_minus_b
);
   import qsqrt_pkg::*;

   assign a_ge_b    = (oper_a >= oper_b);
   assign a_minus_b = oper_a - oper_b;

endmodule

// ===== sv/qsqrt_seq.sv =====
// Sequencer and datapath registers driving the shared compare-subtract unit.
module qsqrt_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start_valid,
   output logic                          start_ready,
   input  logic [qsqrt_pkg::VALUE_W-1:0] start_value,
   output logic                          done_valid,
   input  logic                          done_ack,
   output qsqrt_pkg::result_type         done_result
);
   import qsqrt_pkg::*;

   state_type state_ff, state_in;

   logic [OPER_W-1:0] x_ff;
   logic [OPER_W-1:0] res_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [FRAC_W-1:0] frac_ff;
   logic [INT_W-1:0]  div_ff;
   logic [C_W-1:0]    c_ff;
   logic [D_W-1:0]    d_ff;
   logic [ROOT_W-1:0] root_ff;
   logic              nan_ff;

   logic [OPER_W-1:0] bit_vec;
   logic [OPER_W-1:0] trial;
   logic [OPER_W-1:0] div_rem;
   logic [OPER_W-1:0] oper_a;
   logic [OPER_W-1:0] oper_b;
   logic              ge;
   logic [OPER_W-1:0] diff;
   logic [OPER_W-1:0] res_step;
   logic [OPER_W-1:0] x_step;
   logic [FRAC_W-1:0] quot_next;
   logic              last_step;
   logic [INT_W-1:0]  in_ipart;
   logic [C_W+D_W-1:0] product;

   assign in_ipart  = start_value[VALUE_W-2:FRAC_W];
   assign bit_vec   = OPER_W'(1) << {cnt_ff, 1'b0};
   assign trial     = res_ff + bit_vec;
   assign div_rem   = {{(OPER_W-FRAC_W-1){1'b0}}, x_ff[FRAC_W-1:0], res_ff[FRAC_W-1]};
   assign last_step = (cnt_ff == '0);
   assign quot_next = {res_ff[FRAC_W-2:0], ge};
   assign product   = c_ff * d_ff;

   always_comb begin
      if (state_ff == ST_DIV) begin
         oper_a = div_rem;
         oper_b = {{(OPER_W-INT_W){1'b0}}, div_ff};
      end else begin
         oper_a = x_ff;
         oper_b = trial;
      end
   end

   qsqrt_csub u_csub (
      .oper_a    (oper_a),
      .oper_b    (oper_b),
      .a_ge_b    (ge),
      .a_minus_b (diff)
   );

   assign res_step = ge ? ((res_ff >> 1) + bit_vec) : (res_ff >> 1);
   assign x_step   = ge ? diff : oper_a;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_valid) begin
               if (start_value == '0 || start_value[VALUE_W-1]) begin
                  state_in = ST_DONE;
               end else if (in_ipart != '0) begin
                  state_in = ST_ROOT_C;
               end else begin
                  state_in = ST_ROOT_F;
               end
            end
         end
         ST_ROOT_C: if (last_step) state_in = ST_DIV;
         ST_DIV:    if (last_step) state_in = ST_ROOT_D;
         ST_ROOT_D: if (last_step) state_in = ST_MUL;
         ST_ROOT_F: if (last_step) state_in = ST_DONE;
         ST_MUL:    state_in = ST_DONE;
         ST_DONE:   if (done_ack) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      start_ready        = 1'b0;
      done_valid         = 1'b0;
      done_result.root   = root_ff;
      done_result.is_nan = nan_ff;
      case (state_ff)
         ST_IDLE: start_ready = 1'b1;
         ST_DONE: done_valid  = 1'b1;
         default: begin
            start_ready = 1'b0;
            done_valid  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (start_valid) begin
               if (in_ipart != '0) begin
                  x_ff <= {1'b0, in_ipart, {FRAC_W{1'b0}}};
               end else begin
                  x_ff <= {start_value[FRAC_W-1:0], {FRAC_W{1'b0}}};
               end
               res_ff  <= '0;
               cnt_ff  <= (in_ipart != '0) ? C_START_CNT : F_START_CNT;
               frac_ff <= start_value[FRAC_W-1:0];
               div_ff  <= in_ipart;
               nan_ff  <= start_value[VALUE_W-1];
               root_ff <= '0;
            end
         end
         ST_ROOT_C: begin
            x_ff   <= x_step;
            res_ff <= res_step;
            cnt_ff <= cnt_ff - 1'b1;
            if (last_step) begin
               c_ff   <= res_step[C_W-1:0];
               x_ff   <= '0;
               res_ff <= {{(OPER_W-FRAC_W){1'b0}}, frac_ff};
               cnt_ff <= DIV_START_CNT;
            end
         end
         ST_DIV: begin
            x_ff   <= x_step;
            res_ff <= {{(OPER_W-FRAC_W){1'b0}}, quot_next};
            cnt_ff <= cnt_ff - 1'b1;
            if (last_step) begin
               x_ff   <= ONE_Q + {{(OPER_W-FRAC_W){1'b0}}, quot_next};
               res_ff <= '0;
               cnt_ff <= D_START_CNT;
            end
         end
         ST_ROOT_D: begin
            x_ff   <= x_step;
            res_ff <= res_step;
            cnt_ff <= cnt_ff - 1'b1;
            if (last_step) begin
               d_ff <= res_step[D_W-1:0];
            end
         end
         ST_ROOT_F: begin
            x_ff   <= x_step;
            res_ff <= res_step;
            cnt_ff <= cnt_ff - 1'b1;
            if (last_step) begin
               root_ff <= res_step[ROOT_W-1:0];
            end
         end
         ST_MUL: begin
            root_ff <= product[ROOT_W-1:0];
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== sv/q16_16_square_root_core.sv =====
// Top level: Q16.16 square root core with request handshake and registered response.
//
// Takes a signed Q16.16 request and returns its unsigned Q16.16 root (24 bits); a negative
// request gives root 0 with is_nan set, zero gives zero. One request is worked at a time,
// all root and divide steps going through a single 32-bit compare-subtract unit. A request
// with a nonzero integer part takes 16 root steps, 16 divide steps, 9 root steps and one
// multiply before the hand-off; a pure fraction takes 16 root steps, and zero or negative
// requests go straight to the hand-off. A new request is taken as soon as the previous one
// has moved into the response register, even if that response is still held.
module q16_16_square_root_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [qsqrt_pkg::VALUE_W-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [qsqrt_pkg::ROOT_W-1:0]  rsp_root,
   output logic                          rsp_is_nan
);
   import qsqrt_pkg::*;

   logic              done_valid;
   logic              done_ack;
   result_type        done_result;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROOT_W-1:0] rsp_root_ff;
   logic              rsp_is_nan_ff;

   qsqrt_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start_valid (req_valid),
      .start_ready (req_ready),
      .start_value (req_value),
      .done_valid  (done_valid),
      .done_ack    (done_ack),
      .done_result (done_result)
   );

   assign done_ack = done_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done_ack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done_ack) begin
         rsp_root_ff   <= done_result.root;
         rsp_is_nan_ff <= done_result.is_nan;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_root   = rsp_root_ff;
   assign rsp_is_nan = rsp_is_nan_ff;

   a_nan_zero_root: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_is_nan_ff) |-> (rsp_root_ff == '0))
      else $error("flagged response carries nonzero root");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one in progress");

   a_negative_fast: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_value[VALUE_W-1]) |=> (done_valid && done_result.is_nan))
      else $error("negative request not flagged on the next cycle");

   a_ack_needs_room: assert property (@(posedge clock) disable iff (reset)
      done_ack |-> (done_valid && (!rsp_valid_ff || rsp_ready)))
      else $error("result handed off into a full response register");

endmodule

// ===== bench/q16_16_square_root_core_tb.sv =====
// Testbench: Q16.16 square root core, directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module q16_16_square_root_core_tb;
   import qsqrt_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 60;
   localparam int RANDOM_COUNT = 1200;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [VALUE_W-1:0]  req_value;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [ROOT_W-1:0]   rsp_root;
   logic                rsp_is_nan;

   result_type expected_roots[$];
   int         failure_count = 0;
   int         cycle_count   = 0;
   bit         idle_quiet    = 1'b0;

   q16_16_square_root_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_root   (rsp_root),
      .rsp_is_nan (rsp_is_nan)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] floor_sqrt32(input logic [31:0] x);
      logic [15:0] acc;
      logic [15:0] trial;
      logic [31:0] sq;
      acc = '0;
      for (int b = 15; b >= 0; b--) begin
         trial = acc | (16'h1 << b);
         sq    = trial * trial;
         if (sq <= x) begin
            acc = trial;
         end
      end
      return {16'h0, acc};
   endfunction

   function automatic result_type predict_sqrt(input logic [VALUE_W-1:0] value);
      result_type  r;
      logic [15:0] ipart;
      logic [15:0] fpart;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] product;
      ipart    = value[31:16];
      fpart    = value[15:0];
      r.root   = '0;
      r.is_nan = 1'b0;
      if (value[VALUE_W-1]) begin
         r.is_nan = 1'b1;
      end else if (ipart != 16'h0) begin
         c       = floor_sqrt32({ipart, 16'h0});
         d       = floor_sqrt32(ONE_Q + 32'(fpart / ipart));
         product = c * d;
         r.root  = product[ROOT_W-1:0];
      end else begin
         product = floor_sqrt32({fpart, 16'h0});
         r.root  = product[ROOT_W-1:0];
      end
      return r;
   endfunction

   function automatic int draw_wait();
      return idle_quiet ? 0 : $urandom_range(0, 19);
   endfunction

   task automatic report_failure(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      failure_count++;
   endtask

   task automatic send_request(input logic [VALUE_W-1:0] value);
      int gap;
      gap = draw_wait();
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // requests and responses are logged in one place so queue order is fixed
   always @(posedge clock) begin : monitor
      result_type want;
      if (!reset) begin
         if (req_valid && req_ready === 1'b1) begin
            expected_roots.push_back(predict_sqrt(req_value));
         end
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (expected_roots.size() == 0) begin
               report_failure($sformatf("response with nothing pending: root %06h nan %0b",
                                        rsp_root, rsp_is_nan));
            end else begin
               want = expected_roots.pop_front();
               if (rsp_root !== want.root) begin
                  report_failure($sformatf("root mismatch: got %06h want %06h",
                                           rsp_root, want.root));
               end
               if (rsp_is_nan !== want.is_nan) begin
                  report_failure($sformatf("is_nan mismatch: got %0b want %0b",
                                           rsp_is_nan, want.is_nan));
               end
            end
         end
      end
   end

   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = draw_wait();
         if (stall != 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_ready));
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   task automatic test_zero_and_sign();
      send_request(32'h0000_0000);
      send_request(32'h8000_0000);
      send_request(32'hFFFF_FFFF);
      send_request(32'hFFFF_0000);
      send_request(32'hC000_1234);
   endtask

   task automatic test_fraction_only();
      send_request(32'h0000_0001);
      send_request(32'h0000_0100);
      send_request(32'h0000_4000);
      send_request(32'h0000_8000);
      send_request(32'h0000_FFFF);
   endtask

   task automatic test_integer_part();
      send_request(32'h0001_0000);
      send_request(32'h0001_0001);
      send_request(32'h0001_FFFF);
      send_request(32'h0002_0000);
      send_request(32'h0004_0000);
      send_request(32'h0003_0005);
      send_request(32'h00FF_00FF);
      send_request(32'h1234_5678);
   endtask

   task automatic test_range_extremes();
      send_request(32'h7FFF_0000);
      send_request(32'h7FFF_0001);
      send_request(32'h7FFF_FFFF);
      send_request(32'h5555_AAAA);
      send_request(32'h2AAA_5555);
   endtask

   function automatic logic [VALUE_W-1:0] random_operand();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         return {1'b1, 31'($urandom())};
      end else if (pick < 13) begin
         return '0;
      end else if (pick < 38) begin
         return {16'h0, 16'($urandom())};
      end else if (pick < 50) begin
         return {16'($urandom_range(1, 15)), 16'($urandom())};
      end
      return {1'b0, 31'($urandom())};
   endfunction

   task automatic test_random_operands(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 0) begin
            idle_quiet = ($urandom_range(0, 2) == 0);
         end
         send_request(random_operand());
      end
      idle_quiet = 1'b0;
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_roots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_zero_and_sign();
      test_fraction_only();
      test_integer_part();
      test_range_extremes();
      test_random_operands(RANDOM_COUNT);
      drain_responses();

      if (failure_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
